### src/gmdc_pkg.sv
// Shared types and constants for the grid maze carver.
package gmdc_pkg;

  localparam int unsigned CoordW = 4;
  localparam int unsigned CellW  = 3;

  localparam int unsigned CellTop  = 0;
  localparam int unsigned CellLeft = 1;
  localparam int unsigned CellVis  = 2;

  localparam logic [CellW-1:0] CellFresh = 3'b011;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_CARVED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_FINISHED = 3'd2,
    ST_READ     = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [1:0]        random_draw;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CoordW-1:0] from_x;
    logic [CoordW-1:0] from_y;
    logic [1:0]        carve_direction;
    logic              wall_top;
    logic              wall_bottom;
    logic              wall_left;
    logic              wall_right;
  } out_item_t;

endpackage

### src/gmdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gmdc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/grid_maze_dfs_carver_top.sv
// Top level of the depth-first grid maze carver.
//
// Carves a GRID_SIDE x GRID_SIDE maze by randomised depth-first search; one result
// item per input item, one item in flight at a time. The cell store and the path
// stack are single-port-per-side RAMs and a small sequencer walks them. After
// reset the block runs a clearing pass over all 4**ceil(log2(GRID_SIDE)) cell
// store entries (256 for a 16x16 grid) before it takes an item. A start item
// reruns that pass, then marks its cell visited and pushes it on the path stack.
// A read item reads the cell and its neighbours below and to the right; an advance
// while idle or an unused code goes straight to the output step. An advance item
// scans the four neighbours through the cell store read port, then carves, rejects
// its draw, or pops a cell and scans again while backtracking; it finishes once the
// stack is empty. A result that waits to be taken holds the sequencer in its
// output step.
module grid_maze_dfs_carver_top
  import gmdc_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned CW       = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned AW       = 2 * CW;
  localparam int unsigned CellNum  = 1 << AW;
  localparam int unsigned StackCap = GRID_SIDE * GRID_SIDE + 1;
  localparam int unsigned SAW      = $clog2(StackCap);
  localparam int unsigned DW       = $clog2(StackCap + 1);
  localparam logic [CW-1:0] MaxC   = CW'(GRID_SIDE - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_ADV, S_SCAN, S_DECIDE,
    S_POP, S_CARVE_N, S_CARVE_C, S_READ, S_EMIT
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   clr_q;
  logic            start_pend_q;
  logic [DW-1:0]   depth_q;
  logic [CW-1:0]   here_x_q, here_y_q;
  logic            active_q;
  logic [CW-1:0]   cx_q, cy_q;
  logic [1:0]      draw_q;
  logic [2:0]      cnt_q;
  logic [3:0]      open_q;
  out_item_t       res_q, out_q;
  logic            out_valid_q;
  out_item_t       res_init;

  logic            cell_we;
  logic [AW-1:0]   cell_waddr, cell_raddr;
  logic [CellW-1:0] cell_wdata, cell_rdata;
  logic            stk_we;
  logic [SAW-1:0]  stk_waddr, stk_raddr;
  logic [AW-1:0]   stk_wdata, stk_rdata;

  logic [AW-1:0]   here_addr, draw_addr, scan_addr;
  logic [1:0]      prev_dir;
  logic            prev_ok;

  function automatic logic [CW-1:0] clamp(input logic [CoordW-1:0] v);
    if (int'(v) >= int'(GRID_SIDE)) begin
      return MaxC;
    end
    return CW'(v);
  endfunction

  function automatic logic nbr_ok(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic [1:0] d);
    logic ok;
    case (d)
      DIR_UP:   ok = (y != '0);
      DIR_DOWN: ok = (y != MaxC);
      DIR_LEFT: ok = (x != '0);
      default:  ok = (x != MaxC);
    endcase
    return ok;
  endfunction

  function automatic logic [AW-1:0] nbr_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                             input logic [1:0] d);
    logic [CW-1:0] nx, ny;
    nx = x;
    ny = y;
    case (d)
      DIR_UP:   ny = y - CW'(1);
      DIR_DOWN: ny = y + CW'(1);
      DIR_LEFT: nx = x - CW'(1);
      default:  nx = x + CW'(1);
    endcase
    return {ny, nx};
  endfunction

  assign here_addr = {here_y_q, here_x_q};
  assign draw_addr = nbr_addr(here_x_q, here_y_q, draw_q);
  assign scan_addr = nbr_addr(here_x_q, here_y_q, cnt_q[1:0]);
  assign prev_dir  = cnt_q[1:0] - 2'd1;
  assign prev_ok   = nbr_ok(here_x_q, here_y_q, prev_dir);

  always_comb begin
    res_init        = '0;
    res_init.status = ST_IGNORED;
  end

  // memory port steering
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = clr_q;
    cell_wdata = CellFresh;
    cell_raddr = here_addr;
    stk_we     = 1'b0;
    stk_waddr  = depth_q[SAW-1:0];
    stk_wdata  = here_addr;
    stk_raddr  = SAW'(depth_q - DW'(1));
    case (state_q)
      S_CLEAR: begin
        cell_we = 1'b1;
      end
      S_START: begin
        cell_we    = 1'b1;
        cell_waddr = {cy_q, cx_q};
        cell_wdata = CellFresh | (CellW'(1) << CellVis);
        stk_we     = 1'b1;
        stk_waddr  = '0;
        stk_wdata  = {cy_q, cx_q};
      end
      S_SCAN: begin
        cell_raddr = scan_addr;
      end
      S_DECIDE: begin
        cell_raddr = draw_addr;
      end
      S_CARVE_N: begin
        cell_we    = 1'b1;
        cell_waddr = draw_addr;
        cell_wdata = cell_rdata | (CellW'(1) << CellVis);
        if (draw_q == DIR_DOWN) begin
          cell_wdata[CellTop] = 1'b0;
        end
        if (draw_q == DIR_RIGHT) begin
          cell_wdata[CellLeft] = 1'b0;
        end
        stk_we     = (int'(depth_q) < int'(StackCap));
        cell_raddr = here_addr;
      end
      S_CARVE_C: begin
        cell_we    = 1'b1;
        cell_waddr = here_addr;
        cell_wdata = cell_rdata;
        if (draw_q == DIR_UP) begin
          cell_wdata[CellTop] = 1'b0;
        end else begin
          cell_wdata[CellLeft] = 1'b0;
        end
      end
      S_READ: begin
        case (cnt_q)
          3'd0:    cell_raddr = {cy_q, cx_q};
          3'd1:    cell_raddr = {cy_q + CW'(1), cx_q};
          default: cell_raddr = {cy_q, cx_q + CW'(1)};
        endcase
      end
      default: begin
      end
    endcase
  end

  gmdc_ram #(.Width(CellW), .Depth(CellNum)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  gmdc_ram #(.Width(AW), .Depth(StackCap)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      start_pend_q <= 1'b0;
      depth_q      <= '0;
      here_x_q     <= '0;
      here_y_q     <= '0;
      active_q     <= 1'b0;
      cx_q         <= '0;
      cy_q         <= '0;
      draw_q       <= '0;
      cnt_q        <= '0;
      open_q       <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == '1) begin
            state_q <= start_pend_q ? S_START : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cx_q   <= clamp(in_item_i.cell_x);
            cy_q   <= clamp(in_item_i.cell_y);
            draw_q <= in_item_i.random_draw;
            cnt_q  <= '0;
            res_q  <= res_init;
            case (in_item_i.operation)
              OP_START: begin
                start_pend_q <= 1'b1;
                clr_q        <= '0;
                state_q      <= S_CLEAR;
              end
              OP_ADVANCE: state_q <= active_q ? S_ADV : S_EMIT;
              OP_READ:    state_q <= S_READ;
              default:    state_q <= S_EMIT;
            endcase
          end
        end
        S_START: begin
          start_pend_q <= 1'b0;
          depth_q      <= DW'(1);
          here_x_q     <= cx_q;
          here_y_q     <= cy_q;
          active_q     <= 1'b1;
          res_q.from_x <= CoordW'(cx_q);
          res_q.from_y <= CoordW'(cy_q);
          state_q      <= S_EMIT;
        end
        S_ADV: begin
          cnt_q <= '0;
          if (depth_q == '0) begin
            active_q     <= 1'b0;
            res_q.status <= ST_FINISHED;
            res_q.from_x <= CoordW'(here_x_q);
            res_q.from_y <= CoordW'(here_y_q);
            state_q      <= S_EMIT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q != '0) begin
            open_q[prev_dir] <= prev_ok && !cell_rdata[CellVis];
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (open_q == '0) begin
            depth_q <= depth_q - DW'(1);
            state_q <= S_POP;
          end else if (open_q[draw_q]) begin
            state_q <= S_CARVE_N;
          end else begin
            res_q.status          <= ST_REJECTED;
            res_q.from_x          <= CoordW'(here_x_q);
            res_q.from_y          <= CoordW'(here_y_q);
            res_q.carve_direction <= draw_q;
            state_q               <= S_EMIT;
          end
        end
        S_POP: begin
          here_x_q <= stk_rdata[CW-1:0];
          here_y_q <= stk_rdata[AW-1:CW];
          state_q  <= S_ADV;
        end
        S_CARVE_N: begin
          if (int'(depth_q) < int'(StackCap)) begin
            depth_q <= depth_q + DW'(1);
          end
          res_q.status          <= ST_CARVED;
          res_q.from_x          <= CoordW'(here_x_q);
          res_q.from_y          <= CoordW'(here_y_q);
          res_q.carve_direction <= draw_q;
          if (draw_q[0]) begin
            here_x_q <= draw_addr[CW-1:0];
            here_y_q <= draw_addr[AW-1:CW];
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_CARVE_C;
          end
        end
        S_CARVE_C: begin
          here_x_q <= draw_addr[CW-1:0];
          here_y_q <= draw_addr[AW-1:CW];
          state_q  <= S_EMIT;
        end
        S_READ: begin
          cnt_q        <= cnt_q + 3'd1;
          res_q.status <= ST_READ;
          res_q.from_x <= CoordW'(cx_q);
          res_q.from_y <= CoordW'(cy_q);
          case (cnt_q)
            3'd0: begin
            end
            3'd1: begin
              res_q.wall_top  <= cell_rdata[CellTop];
              res_q.wall_left <= cell_rdata[CellLeft];
            end
            3'd2: begin
              res_q.wall_bottom <= (cy_q == MaxC) ? 1'b1 : cell_rdata[CellTop];
            end
            default: begin
              res_q.wall_right <= (cx_q == MaxC) ? 1'b1 : cell_rdata[CellLeft];
              state_q          <= S_EMIT;
            end
          endcase
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
